// File: rtl/core/mcps_pkg.sv
package mcps_pkg;

    localparam int MOM_W   = 4;
    localparam int SPIN_W  = 8;
    localparam int RAND_W  = 16;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] ORBITAL_COUNT_RESET = 8'd128;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_LOAD        = 2'd0,
        OP_SAMPLE_PAR  = 2'd1,
        OP_SAMPLE_ANTI = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

endpackage

// File: rtl/core/momentum_conserving_pair_sampler.sv
// Sequence: a load or an unused opcode goes from acceptance through ST_DONE to the output
// register; a sample goes through ST_OCC_B, ST_OCC_SUM, ST_WALK, ST_PICK, ST_FETCH, ST_LIST
// and ST_DONE, and skips ST_PICK, ST_FETCH and ST_LIST for an empty candidate set.
// Throughput: one item at a time; the next is taken once the result sits in the output
// register. The sample time is set by the walk over min(orbital_count, MAX_ORBITALS)
// table entries, one table read per cycle.
// Reset (aresetn low at a clock edge) clears the momentum map valid bits, the sequencer and
// the output register, and sets orbital_count to 128; the momentum tables keep their contents.
module momentum_conserving_pair_sampler #(
    parameter int MAX_ORBITALS = 128,
    parameter int MAX_MOMENTUM = 7
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mcps_pkg::COUNT_W-1:0]    cfg_wr_data,  // orbital_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_index[6:0], load_kx[10:7], load_ky[14:11], first_occupied[22:15],
    // second_occupied[30:23], spin_bit[31], random_fraction[47:32], coin_bit[48], zeros
    input  logic [mcps_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [mcps_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // first_result[7:0], second_result[15:8], inverse_probability[23:16]
    output logic [mcps_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic [mcps_pkg::M_TUSER_W-1:0]  m_tuser
);
    import mcps_pkg::*;

    localparam int IW        = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int CW        = $clog2(MAX_ORBITALS + 1);
    localparam int SIDE      = 2 * MAX_MOMENTUM + 1;
    localparam int MAP_DEPTH = SIDE * SIDE;
    localparam int SW        = $clog2(MAP_DEPTH);
    localparam int PW        = RAND_W + CW;

    localparam logic signed [5:0] KMAX = 6'(MAX_MOMENTUM);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OCC_B,
        ST_OCC_SUM,
        ST_WALK,
        ST_PICK,
        ST_FETCH,
        ST_LIST,
        ST_DONE
    } state_t;

    function automatic logic in_range(input logic signed [5:0] k);
        return (k >= -KMAX) && (k <= KMAX);
    endfunction

    function automatic logic [SW-1:0] map_slot(input logic signed [5:0] x,
                                               input logic signed [5:0] y);
        logic [5:0] xo;
        logic [5:0] yo;
        xo = 6'(x + KMAX);
        yo = 6'(y + KMAX);
        return SW'(int'(xo) + SIDE * int'(yo));
    endfunction

    // input fields
    logic [6:0]               in_load_index;
    logic signed [MOM_W-1:0]  in_load_kx;
    logic signed [MOM_W-1:0]  in_load_ky;
    logic [SPIN_W-1:0]        in_first;
    logic [SPIN_W-1:0]        in_second;
    logic                     in_spin;
    logic [RAND_W-1:0]        in_rand;
    logic                     in_coin;
    opcode_t                  in_op;

    assign in_load_index = s_tdata[6:0];
    assign in_load_kx    = s_tdata[10:7];
    assign in_load_ky    = s_tdata[14:11];
    assign in_first      = s_tdata[22:15];
    assign in_second     = s_tdata[30:23];
    assign in_spin       = s_tdata[31];
    assign in_rand       = s_tdata[47:32];
    assign in_coin       = s_tdata[48];
    assign in_op         = opcode_t'(s_tuser);

    // control registers
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic [MAP_DEPTH-1:0] map_vld_reg, map_vld_next;

    // payload registers
    logic [CW-1:0]           limit_reg, limit_next;
    logic [CW-1:0]           walk_idx_reg, walk_idx_next;
    logic [CW-1:0]           members_reg, members_next;
    logic [CW-1:0]           pick_reg, pick_next;
    logic [IW-1:0]           s1_idx_reg, s1_idx_next;
    logic [IW-1:0]           s2_idx_reg, s2_idx_next;
    logic                    s2_inrange_reg, s2_inrange_next;
    logic signed [MOM_W-1:0] ax_reg, ax_next;
    logic signed [MOM_W-1:0] ay_reg, ay_next;
    logic signed [4:0]       ktx_reg, ktx_next;
    logic signed [4:0]       kty_reg, kty_next;
    logic                    par_reg, par_next;
    logic                    spin_reg, spin_next;
    logic                    coin_reg, coin_next;
    logic [RAND_W-1:0]       rand_reg, rand_next;
    logic [IW-1:0]           occ_b_reg, occ_b_next;
    logic                    a_ok_reg, a_ok_next;
    logic                    b_ok_reg, b_ok_next;
    logic [M_TDATA_W-1:0]    res_data_reg, res_data_next;
    logic                    res_status_reg, res_status_next;

    // memories
    logic [2*MOM_W-1:0] tbl_mem [MAX_ORBITALS];
    logic [2*MOM_W-1:0] tbl_q;
    logic [IW-1:0]      tbl_rd_addr;
    logic               tbl_we;
    logic [IW-1:0]      map_mem [MAP_DEPTH];
    logic [IW-1:0]      map_q;
    logic               map_vld_q;
    logic               map_we;
    logic [SW-1:0]      ld_slot;
    logic [SW-1:0]      walk_slot;
    logic [2*IW-1:0]    list_mem [MAX_ORBITALS];
    logic [2*IW-1:0]    list_q;
    logic               list_we;

    // datapath
    logic                    accept;
    logic                    load_ok;
    logic signed [5:0]       ld_kx6, ld_ky6;
    logic signed [MOM_W-1:0] tq_kx, tq_ky;
    logic signed [5:0]       px, py;
    logic                    p_inrange;
    logic                    is_member;
    logic [PW-1:0]           product;
    logic [IW-1:0]           pick_i, pick_j;
    logic                    res_first_spin, res_second_spin;
    logic [7:0]              res_first, res_second, res_inv;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign load_ok = int'(in_load_index) < MAX_ORBITALS;
    assign ld_kx6  = 6'(in_load_kx);
    assign ld_ky6  = 6'(in_load_ky);
    assign ld_slot = (in_range(ld_kx6) && in_range(ld_ky6)) ? map_slot(ld_kx6, ld_ky6) : '0;
    assign tbl_we  = accept && (in_op == OP_LOAD) && load_ok;
    assign map_we  = tbl_we && in_range(ld_kx6) && in_range(ld_ky6);

    assign tq_kx     = tbl_q[MOM_W-1:0];
    assign tq_ky     = tbl_q[2*MOM_W-1:MOM_W];
    assign px        = 6'(ktx_reg) - 6'(tq_kx);
    assign py        = 6'(kty_reg) - 6'(tq_ky);
    assign p_inrange = in_range(px) && in_range(py);
    assign walk_slot = p_inrange ? map_slot(px, py) : '0;

    assign is_member = s2_valid_reg && s2_inrange_reg && map_vld_q
                       && (CW'(map_q) < limit_reg)
                       && !(par_reg && (map_q == s2_idx_reg));
    assign list_we   = is_member;

    assign product = PW'(rand_reg) * PW'(members_reg);

    assign pick_i          = list_q[IW-1:0];
    assign pick_j          = list_q[2*IW-1:IW];
    assign res_first_spin  = par_reg ? spin_reg : coin_reg;
    assign res_second_spin = par_reg ? spin_reg : ~coin_reg;
    assign res_first       = 8'({pick_i, res_first_spin});
    assign res_second      = 8'({pick_j, res_second_spin});
    assign res_inv         = par_reg ? 8'(members_reg >> 1) : 8'(members_reg);

    always_comb begin
        case (state_reg)
            ST_IDLE:  tbl_rd_addr = IW'(in_first[7:1]);
            ST_OCC_B: tbl_rd_addr = occ_b_reg;
            default:  tbl_rd_addr = walk_idx_reg[IW-1:0];
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        s1_valid_next   = 1'b0;
        s2_valid_next   = s1_valid_reg;
        map_vld_next    = map_vld_reg;
        limit_next      = limit_reg;
        walk_idx_next   = walk_idx_reg;
        members_next    = members_reg;
        pick_next       = pick_reg;
        s1_idx_next     = walk_idx_reg[IW-1:0];
        s2_idx_next     = s1_idx_reg;
        s2_inrange_next = p_inrange;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        ktx_next        = ktx_reg;
        kty_next        = kty_reg;
        par_next        = par_reg;
        spin_next       = spin_reg;
        coin_next       = coin_reg;
        rand_next       = rand_reg;
        occ_b_next      = occ_b_reg;
        a_ok_next       = a_ok_reg;
        b_ok_next       = b_ok_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_wr_en) begin
            count_next = cfg_wr_data;
        end
        if (map_we) begin
            map_vld_next[ld_slot] = 1'b1;
        end
        if (is_member) begin
            members_next = members_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_data_next   = '0;
                    res_status_next = STATUS_OK;
                    par_next        = (in_op == OP_SAMPLE_PAR);
                    spin_next       = in_spin;
                    coin_next       = in_coin;
                    rand_next       = in_rand;
                    occ_b_next      = IW'(in_second[7:1]);
                    a_ok_next       = int'(in_first[7:1]) < MAX_ORBITALS;
                    b_ok_next       = int'(in_second[7:1]) < MAX_ORBITALS;
                    walk_idx_next   = '0;
                    members_next    = '0;
                    limit_next      = (int'(count_reg) > MAX_ORBITALS) ?
                                      CW'(MAX_ORBITALS) : CW'(count_reg);
                    if ((in_op == OP_SAMPLE_PAR) || (in_op == OP_SAMPLE_ANTI)) begin
                        state_next = ST_OCC_B;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_OCC_B: begin
                ax_next    = a_ok_reg ? tq_kx : '0;
                ay_next    = a_ok_reg ? tq_ky : '0;
                state_next = ST_OCC_SUM;
            end
            ST_OCC_SUM: begin
                ktx_next   = 5'(ax_reg) + 5'(b_ok_reg ? tq_kx : 4'sd0);
                kty_next   = 5'(ay_reg) + 5'(b_ok_reg ? tq_ky : 4'sd0);
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // issue one table read per cycle, then drain the two lookup stages
                if (walk_idx_reg < limit_reg) begin
                    s1_valid_next = 1'b1;
                    walk_idx_next = walk_idx_reg + CW'(1);
                end else if (!s1_valid_reg && !s2_valid_reg) begin
                    if (members_reg == '0) begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                pick_next  = product[RAND_W +: CW];
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_LIST;
            end
            ST_LIST: begin
                res_data_next = {res_inv, res_second, res_first};
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= ORBITAL_COUNT_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            map_vld_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            map_vld_reg  <= map_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg      <= limit_next;
        walk_idx_reg   <= walk_idx_next;
        members_reg    <= members_next;
        pick_reg       <= pick_next;
        s1_idx_reg     <= s1_idx_next;
        s2_idx_reg     <= s2_idx_next;
        s2_inrange_reg <= s2_inrange_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        ktx_reg        <= ktx_next;
        kty_reg        <= kty_next;
        par_reg        <= par_next;
        spin_reg       <= spin_next;
        coin_reg       <= coin_next;
        rand_reg       <= rand_next;
        occ_b_reg      <= occ_b_next;
        a_ok_reg       <= a_ok_next;
        b_ok_reg       <= b_ok_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[IW'(in_load_index)] <= {in_load_ky, in_load_kx};
        end
        tbl_q <= tbl_mem[tbl_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[ld_slot] <= IW'(in_load_index);
        end
        map_q     <= map_mem[walk_slot];
        map_vld_q <= map_vld_reg[walk_slot];
    end

    // candidate list: member number n holds {partner, orbital}
    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[members_reg[IW-1:0]] <= {map_q, s2_idx_reg};
        end
        list_q <= list_mem[pick_reg[IW-1:0]];
    end

`ifndef SYNTHESIS
    a_members_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (members_reg <= walk_idx_reg))
        else $error("member count ran ahead of the walk");

    a_pick_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (pick_reg < members_reg))
        else $error("picked member beyond candidate set");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == STATUS_EMPTY)) |-> (m_tdata_reg == '0))
        else $error("empty-set beat carries nonzero data");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_walk_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("pick started with lookups in flight");
`endif

endmodule
